[rtl/vls_pkg.sv]
// vls_pkg: shared types and constants for the voxel line stepper.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package vls_pkg;

  localparam int STEP_W           = 6;   // width of step index / span
  localparam int COORD_BITS_DEF   = 16;
  localparam int MAX_SPAN_DEF     = 63;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPAN,
    ST_RUN
  } vls_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;   // capture endpoints, diffs, directions
    logic init_run;  // compute span, clear step accumulators
    logic emit;      // load output register and advance one step
  } vls_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;      // current beat ends the line
  } vls_stat_t;

endpackage

[rtl/voxel_line_stepper.sv]
// voxel_line_stepper: top level, joins vls_ctrl and vls_datapath.
// Depends on vls_pkg, vls_ctrl and vls_datapath.
`timescale 1ns / 1ps

// Takes a start and an end grid point and emits the stair-like voxel line
// between them, one voxel beat per cycle while the output is not stalled,
// from step 0 to the span (largest per-axis distance), the last beat
// marked. Equal points give one beat; a span above MAX_SPAN gives a single
// beat with span_overflow set and zero coordinates. One line at a time: an
// input beat is captured, then its span is computed, and then it gives
// span+1 output beats. The per-step work is a running remainder add and
// compare-subtract per axis, so no divider is needed.
// The last output beat may still sit in the output register while the next
// input beat is taken.
module voxel_line_stepper
  import vls_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_SPAN   = MAX_SPAN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_start_u,
  input  logic [COORD_BITS-1:0] in_start_v,
  input  logic [COORD_BITS-1:0] in_start_t,
  input  logic [COORD_BITS-1:0] in_end_u,
  input  logic [COORD_BITS-1:0] in_end_v,
  input  logic [COORD_BITS-1:0] in_end_t,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_point_u,
  output logic [COORD_BITS-1:0] out_point_v,
  output logic [COORD_BITS-1:0] out_point_t,
  output logic [STEP_W-1:0]     out_step_number,
  output logic                  out_last_point,
  output logic                  out_span_overflow
);

  vls_cmd_t  cmd;
  vls_stat_t stat;

  vls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  vls_datapath #(
    .COORD_BITS (COORD_BITS),
    .MAX_SPAN   (MAX_SPAN)
  ) u_dp (
    .clk               (clk),
    .cmd               (cmd),
    .stat              (stat),
    .in_start_u        (in_start_u),
    .in_start_v        (in_start_v),
    .in_start_t        (in_start_t),
    .in_end_u          (in_end_u),
    .in_end_v          (in_end_v),
    .in_end_t          (in_end_t),
    .out_point_u       (out_point_u),
    .out_point_v       (out_point_v),
    .out_point_t       (out_point_t),
    .out_step_number   (out_step_number),
    .out_last_point    (out_last_point),
    .out_span_overflow (out_span_overflow)
  );

endmodule

[rtl/vls_ctrl.sv]
// vls_ctrl: sequencer for the voxel line stepper; owns the handshakes.
// Depends on vls_pkg for the state, command and status types.
`timescale 1ns / 1ps

module vls_ctrl
  import vls_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  vls_stat_t stat,
  output vls_cmd_t  cmd
);

  vls_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SPAN;
        end
      end
      ST_SPAN: begin
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (out_free && stat.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        // no input beat is taken while reset is held
        in_stall    = !rst_n;
        cmd.load_in = in_valid && rst_n;
      end
      ST_SPAN: begin
        cmd.init_run = 1'b1;
      end
      ST_RUN: begin
        cmd.emit = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/vls_datapath.sv]
// vls_datapath: endpoint registers, per-axis DDA accumulators, output register.
// Depends on vls_pkg; driven by commands from vls_ctrl.
`timescale 1ns / 1ps

module vls_datapath
  import vls_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_SPAN   = MAX_SPAN_DEF
) (
  input  logic                  clk,
  input  vls_cmd_t              cmd,
  output vls_stat_t             stat,
  input  logic [COORD_BITS-1:0] in_start_u,
  input  logic [COORD_BITS-1:0] in_start_v,
  input  logic [COORD_BITS-1:0] in_start_t,
  input  logic [COORD_BITS-1:0] in_end_u,
  input  logic [COORD_BITS-1:0] in_end_v,
  input  logic [COORD_BITS-1:0] in_end_t,
  output logic [COORD_BITS-1:0] out_point_u,
  output logic [COORD_BITS-1:0] out_point_v,
  output logic [COORD_BITS-1:0] out_point_t,
  output logic [STEP_W-1:0]     out_step_number,
  output logic                  out_last_point,
  output logic                  out_span_overflow
);

  localparam int SW = (COORD_BITS > STEP_W) ? COORD_BITS : STEP_W;

  logic [COORD_BITS-1:0] start_in [3];
  logic [COORD_BITS-1:0] end_in   [3];

  logic [COORD_BITS-1:0] a_r   [3];
  logic                  dir_r [3];   // 1: coordinate grows toward end
  logic [SW-1:0]         d_r   [3];
  logic [STEP_W-1:0]     q_r   [3];   // floor(ip*d/np)
  logic [STEP_W-1:0]     rem_r [3];   // ip*d mod np
  logic [STEP_W-1:0]     np_r;
  logic [STEP_W-1:0]     ip_r;
  logic                  ovf_r;

  logic [SW-1:0]         m01, np_full;
  logic [STEP_W:0]       rsum  [3];
  logic                  carry [3];
  logic [COORD_BITS-1:0] point [3];
  logic [SW-1:0]         psum  [3];

  logic [COORD_BITS-1:0] pu_r, pv_r, pt_r;
  logic [STEP_W-1:0]     step_r;
  logic                  last_r, ovf_out_r;

  assign start_in[0] = in_start_u;
  assign start_in[1] = in_start_v;
  assign start_in[2] = in_start_t;
  assign end_in[0]   = in_end_u;
  assign end_in[1]   = in_end_v;
  assign end_in[2]   = in_end_t;

  // span = largest per-axis distance
  assign m01     = (d_r[0] > d_r[1]) ? d_r[0] : d_r[1];
  assign np_full = (m01 > d_r[2]) ? m01 : d_r[2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rsum[k]  = {1'b0, rem_r[k]} + {1'b0, d_r[k][STEP_W-1:0]};
      carry[k] = rsum[k] >= {1'b0, np_r};
      if (dir_r[k]) begin
        psum[k] = SW'(a_r[k]) + SW'(q_r[k]);
      end else begin
        psum[k] = SW'(a_r[k]) - SW'(q_r[k]);
      end
      point[k] = psum[k][COORD_BITS-1:0];
    end
  end

  assign stat.last = ovf_r || (ip_r == np_r);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      for (int k = 0; k < 3; k++) begin
        a_r[k]   <= start_in[k];
        dir_r[k] <= end_in[k] > start_in[k];
        if (end_in[k] > start_in[k]) begin
          d_r[k] <= SW'(end_in[k] - start_in[k]);
        end else begin
          d_r[k] <= SW'(start_in[k] - end_in[k]);
        end
      end
    end

    if (cmd.init_run) begin
      ovf_r <= np_full > SW'(MAX_SPAN);
      np_r  <= np_full[STEP_W-1:0];
      ip_r  <= '0;
      for (int k = 0; k < 3; k++) begin
        q_r[k]   <= '0;
        rem_r[k] <= '0;
      end
    end else if (cmd.emit) begin
      ip_r <= ip_r + STEP_W'(1);
      for (int k = 0; k < 3; k++) begin
        if (carry[k]) begin
          rem_r[k] <= STEP_W'(rsum[k] - {1'b0, np_r});
          q_r[k]   <= q_r[k] + STEP_W'(1);
        end else begin
          rem_r[k] <= rsum[k][STEP_W-1:0];
        end
      end
    end

    if (cmd.emit) begin
      last_r    <= stat.last;
      ovf_out_r <= ovf_r;
      if (ovf_r) begin
        pu_r   <= '0;
        pv_r   <= '0;
        pt_r   <= '0;
        step_r <= '0;
      end else begin
        pu_r   <= point[0];
        pv_r   <= point[1];
        pt_r   <= point[2];
        step_r <= ip_r;
      end
    end
  end

  assign out_point_u       = pu_r;
  assign out_point_v       = pv_r;
  assign out_point_t       = pt_r;
  assign out_step_number   = step_r;
  assign out_last_point    = last_r;
  assign out_span_overflow = ovf_out_r;

endmodule

[rtl/vls_checker.sv]
// vls_checker: port-level assertions for voxel_line_stepper, bound to the top.
// Depends on vls_pkg for the step index width.
`timescale 1ns / 1ps

module vls_checker
  import vls_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS-1:0] out_point_u,
  input logic [COORD_BITS-1:0] out_point_v,
  input logic [COORD_BITS-1:0] out_point_t,
  input logic [STEP_W-1:0]     out_step_number,
  input logic                  out_last_point,
  input logic                  out_span_overflow
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_point_u) &&
      $stable(out_point_v) && $stable(out_point_t) &&
      $stable(out_step_number) && $stable(out_last_point) &&
      $stable(out_span_overflow))
    else $error("output beat changed while stalled");

  // overflow beat is a lone, zeroed, final beat
  a_ovf_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_span_overflow |-> out_last_point &&
      out_step_number == '0 && out_point_u == '0 &&
      out_point_v == '0 && out_point_t == '0)
    else $error("overflow beat malformed");

  // taken non-final beat is followed at once by the next step
  a_next_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_point |=>
      out_valid && out_step_number == $past(out_step_number) + 6'd1)
    else $error("step sequence broken");

  // one line in flight: stall right after an input beat
  a_one_line: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a line is in progress");

endmodule

bind voxel_line_stepper vls_checker #(.COORD_BITS(COORD_BITS)) u_vls_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_point_u       (out_point_u),
  .out_point_v       (out_point_v),
  .out_point_t       (out_point_t),
  .out_step_number   (out_step_number),
  .out_last_point    (out_last_point),
  .out_span_overflow (out_span_overflow)
);

[bench/tb.sv]
// tb: self-checking bench for voxel_line_stepper; predicts every voxel beat of each line.
// Depends on vls_pkg and the voxel_line_stepper RTL only.
`timescale 1ns / 1ps

module tb;
  import vls_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int unsigned COORD_MAX = (1 << CW) - 1;
  localparam int unsigned SPAN_LIMIT = MAX_SPAN_DEF;
  localparam int RANDOM_LINES = 360;
  localparam int DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef logic [2:0][CW-1:0] triple_t;  // index 0 = u, 1 = v, 2 = t

  typedef struct packed {
    logic [CW-1:0]     u;
    logic [CW-1:0]     v;
    logic [CW-1:0]     t;
    logic [STEP_W-1:0] step;
    logic              last;
    logic              ovf;
  } voxel_t;

  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_HEAVY} stall_mode_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [CW-1:0]     in_start_u, in_start_v, in_start_t;
  logic [CW-1:0]     in_end_u, in_end_v, in_end_t;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CW-1:0]     out_point_u, out_point_v, out_point_t;
  logic [STEP_W-1:0] out_step_number;
  logic              out_last_point;
  logic              out_span_overflow;

  voxel_t      expected_voxels[$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned mode_left = 0;

  voxel_line_stepper dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_u       (in_start_u),
    .in_start_v       (in_start_v),
    .in_start_t       (in_start_t),
    .in_end_u         (in_end_u),
    .in_end_v         (in_end_v),
    .in_end_t         (in_end_t),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_u      (out_point_u),
    .out_point_v      (out_point_v),
    .out_point_t      (out_point_t),
    .out_step_number  (out_step_number),
    .out_last_point   (out_last_point),
    .out_span_overflow(out_span_overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d voxel beats still expected", $time,
               expected_voxels.size());
      $display("voxel_line_stepper regression: fail");
      $finish;
    end
  end

  function automatic void queue_voxel(input voxel_t vx);
    expected_voxels.insert(expected_voxels.size(), vx);
  endfunction

  // All voxels of one line, in emit order.
  function automatic void predict_line(input triple_t a, input triple_t b);
    int unsigned delta[3];
    int unsigned span;
    int unsigned off;
    int unsigned ip;
    int k;
    voxel_t vx;
    span = 0;
    for (k = 0; k < 3; k++) begin
      delta[k] = (b[k] > a[k]) ? 32'(b[k] - a[k]) : 32'(a[k] - b[k]);
      if (delta[k] > span) span = delta[k];
    end
    if (span > SPAN_LIMIT) begin
      vx = '0;
      vx.last = 1'b1;
      vx.ovf = 1'b1;
      queue_voxel(vx);
    end else if (span == 0) begin
      vx = '0;
      vx.u = a[0];
      vx.v = a[1];
      vx.t = a[2];
      vx.last = 1'b1;
      queue_voxel(vx);
    end else begin
      for (ip = 0; ip <= span; ip++) begin
        vx = '0;
        for (k = 0; k < 3; k++) begin
          off = (ip * delta[k]) / span;
          vx.u = (k == 0) ? ((b[0] > a[0]) ? a[0] + off[CW-1:0] : a[0] - off[CW-1:0]) : vx.u;
          vx.v = (k == 1) ? ((b[1] > a[1]) ? a[1] + off[CW-1:0] : a[1] - off[CW-1:0]) : vx.v;
          vx.t = (k == 2) ? ((b[2] > a[2]) ? a[2] + off[CW-1:0] : a[2] - off[CW-1:0]) : vx.t;
        end
        vx.step = ip[STEP_W-1:0];
        vx.last = (ip == span);
        queue_voxel(vx);
      end
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    voxel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_voxels.size() == 0) begin
        $display("%0t: unexpected voxel beat, expected none, got (%0d,%0d,%0d) step %0d",
                 $time, out_point_u, out_point_v, out_point_t, out_step_number);
        mismatches++;
      end else begin
        want = expected_voxels.pop_front();
        check_field("point_u", 32'(want.u), 32'(out_point_u));
        check_field("point_v", 32'(want.v), 32'(out_point_v));
        check_field("point_t", 32'(want.t), 32'(out_point_t));
        check_field("step_number", 32'(want.step), 32'(out_step_number));
        check_field("last_point", 32'(want.last), 32'(out_last_point));
        check_field("span_overflow", 32'(want.ovf), 32'(out_span_overflow));
      end
    end
  end

  // Receiver backpressure: switches between no, sparse and heavy stalling.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      case ($urandom_range(0, 2))
        0: stall_mode = STALL_NONE;
        1: stall_mode = STALL_SPARSE;
        default: stall_mode = STALL_HEAVY;
      endcase
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // Called and returns at a falling edge; valid stays high within a burst.
  task automatic send_line(input triple_t a, input triple_t b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_start_u = a[0];
    in_start_v = a[1];
    in_start_t = a[2];
    in_end_u = b[0];
    in_end_v = b[1];
    in_end_t = b[2];
    do @(posedge clk); while (in_stall);
    predict_line(a, b);
    @(negedge clk);
  endtask

  function automatic triple_t mk(input int unsigned u, input int unsigned v,
                                 input int unsigned t);
    triple_t p;
    p[0] = u[CW-1:0];
    p[1] = v[CW-1:0];
    p[2] = t[CW-1:0];
    return p;
  endfunction

  // Start coordinates cluster at both ends of the range now and then.
  function automatic logic [CW-1:0] pick_coord();
    int unsigned r;
    case ($urandom_range(0, 3))
      0: r = $urandom_range(0, 70);
      1: r = COORD_MAX - $urandom_range(0, 70);
      default: r = $urandom;
    endcase
    return r[CW-1:0];
  endfunction

  // End point whose largest axis distance is exactly span.
  function automatic triple_t pick_end(input triple_t a, input int unsigned span);
    triple_t b;
    int unsigned reach;
    int unsigned av;
    int k;
    int major;
    major = $urandom_range(0, 2);
    for (k = 0; k < 3; k++) begin
      av = 32'(a[k]);
      reach = (k == major) ? span : $urandom_range(0, span);
      if (($urandom_range(0, 1) == 1 && av + reach <= COORD_MAX) || av < reach)
        av = av + reach;
      else
        av = av - reach;
      b[k] = av[CW-1:0];
    end
    return b;
  endfunction

  task automatic test_equal_points();
    send_line(mk(0, 0, 0), mk(0, 0, 0));
    send_line(mk(COORD_MAX, COORD_MAX, COORD_MAX), mk(COORD_MAX, COORD_MAX, COORD_MAX));
    send_line(mk('h1234, 'hABCD, 'h5A5A), mk('h1234, 'hABCD, 'h5A5A));
  endtask

  task automatic test_short_lines();
    send_line(mk(10, 20, 30), mk(11, 20, 30));
    send_line(mk(10, 20, 30), mk(10, 21, 30));
    send_line(mk(10, 20, 30), mk(10, 20, 31));
    send_line(mk(1, 1, 1), mk(0, 0, 0));
    send_line(mk(100, 200, 300), mk(163, 183, 295));
  endtask

  task automatic test_span_limit();
    send_line(mk(0, 0, 0), mk(SPAN_LIMIT, SPAN_LIMIT, SPAN_LIMIT));
    send_line(mk(COORD_MAX, COORD_MAX, COORD_MAX),
              mk(COORD_MAX - SPAN_LIMIT, COORD_MAX - SPAN_LIMIT, COORD_MAX - SPAN_LIMIT));
    send_line(mk(0, COORD_MAX, 'h8000), mk(SPAN_LIMIT, COORD_MAX - 40, 'h8000 - 7));
    send_line(mk('h5555, 'hAAAA, 'h00FF), mk('h5555 - SPAN_LIMIT, 'hAAAA + 1, 'h00FF + 62));
  endtask

  task automatic test_span_overflow();
    send_line(mk(0, 0, 0), mk(SPAN_LIMIT + 1, 0, 0));
    send_line(mk(COORD_MAX, 5, 5), mk(COORD_MAX, 5, COORD_MAX));
    send_line(mk(0, 0, 0), mk(COORD_MAX, COORD_MAX, COORD_MAX));
    send_line(mk(COORD_MAX, 0, COORD_MAX), mk(0, COORD_MAX, 5));
  endtask

  task automatic test_random_lines();
    triple_t a;
    triple_t b;
    int unsigned kind;
    int n;
    int k;
    for (n = 0; n < RANDOM_LINES; n++) begin
      for (k = 0; k < 3; k++) a[k] = pick_coord();
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        for (k = 0; k < 3; k++) b[k] = CW'($urandom);
      end else if (kind < 10) begin
        b = pick_end(a, $urandom_range(SPAN_LIMIT + 1, SPAN_LIMIT + 16));
      end else if (kind < 16) begin
        b = a;
      end else if (kind < 60) begin
        b = pick_end(a, $urandom_range(1, 12));
      end else begin
        b = pick_end(a, $urandom_range(1, SPAN_LIMIT));
      end
      send_line(a, b);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_start_u = '0;
    in_start_v = '0;
    in_start_t = '0;
    in_end_u = '0;
    in_end_v = '0;
    in_end_t = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_equal_points();
    test_short_lines();
    test_span_limit();
    test_span_overflow();
    test_random_lines();
    in_valid = 1'b0;

    while (expected_voxels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("voxel_line_stepper regression: pass");
    end else begin
      $display("voxel_line_stepper regression: fail");
    end
    $finish;
  end

endmodule
